// ===== rtl/adq_pkg.sv =====
package adq_pkg;

  // operation codes on in_kind
  localparam logic [1:0] KIND_INS_REAR  = 2'd0;
  localparam logic [1:0] KIND_INS_FRONT = 2'd1;
  localparam logic [1:0] KIND_DEL_REAR  = 2'd2;
  localparam logic [1:0] KIND_DEL_FRONT = 2'd3;

  // result codes on out_status
  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_REAR_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY         = 2'd2;
  localparam logic [1:0] ST_FRONT_BLOCKED = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

// ===== rtl/adq_ctrl.sv =====
module adq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output adq_pkg::cmd_t    cmd
);

  adq_pkg::state_t state_r;
  adq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= adq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      adq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = adq_pkg::S_EXEC;
      end
      adq_pkg::S_EXEC: begin
        state_nxt = adq_pkg::S_DONE;
      end
      adq_pkg::S_DONE: begin
        if (out_ready) state_nxt = adq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = adq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      adq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      adq_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      adq_pkg::S_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/adq_dpath.sv =====
module adq_dpath #(
  parameter int DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  adq_pkg::cmd_t       cmd,
  input  logic         [1:0]  in_kind,
  input  logic signed  [31:0] in_value,
  output logic         [1:0]  out_status,
  output logic signed  [31:0] out_removed
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  logic [31:0] mem [DEPTH];

  logic [1:0]        kind_r;
  logic [31:0]       value_r;
  logic [IW-1:0]     front_r, front_nxt;
  logic [IW-1:0]     rear_r, rear_nxt;
  logic              empty_r, empty_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              del_ok_r, del_ok_nxt;
  logic [31:0]       rd_data_r;
  logic              wr_en, rd_en;
  logic [IW-1:0]     addr;

  always_comb begin
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    empty_nxt  = empty_r;
    status_nxt = adq_pkg::ST_OK;
    del_ok_nxt = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    addr       = rear_r;
    unique case (kind_r)
      adq_pkg::KIND_INS_REAR: begin
        if (empty_r) begin
          // front already sits at slot 0 when empty
          wr_en     = 1'b1;
          addr      = '0;
          rear_nxt  = '0;
          empty_nxt = 1'b0;
        end else if (rear_r == LAST) begin
          status_nxt = adq_pkg::ST_REAR_FULL;
        end else begin
          wr_en    = 1'b1;
          addr     = rear_r + 1'b1;
          rear_nxt = rear_r + 1'b1;
        end
      end
      adq_pkg::KIND_INS_FRONT: begin
        if (front_r != '0) begin
          wr_en     = 1'b1;
          addr      = front_r - 1'b1;
          front_nxt = front_r - 1'b1;
        end else if (empty_r) begin
          wr_en     = 1'b1;
          addr      = '0;
          rear_nxt  = '0;
          empty_nxt = 1'b0;
        end else begin
          status_nxt = adq_pkg::ST_FRONT_BLOCKED;
        end
      end
      adq_pkg::KIND_DEL_REAR: begin
        if (empty_r) begin
          status_nxt = adq_pkg::ST_EMPTY;
        end else begin
          rd_en      = 1'b1;
          del_ok_nxt = 1'b1;
          addr       = rear_r;
          if (rear_r == front_r) begin
            front_nxt = '0;
            rear_nxt  = '0;
            empty_nxt = 1'b1;
          end else begin
            rear_nxt = rear_r - 1'b1;
          end
        end
      end
      adq_pkg::KIND_DEL_FRONT: begin
        if (empty_r) begin
          status_nxt = adq_pkg::ST_EMPTY;
        end else begin
          rd_en      = 1'b1;
          del_ok_nxt = 1'b1;
          addr       = front_r;
          if (rear_r == front_r) begin
            front_nxt = '0;
            rear_nxt  = '0;
            empty_nxt = 1'b1;
          end else begin
            front_nxt = front_r + 1'b1;
          end
        end
      end
      default: begin
        status_nxt = adq_pkg::ST_OK;
      end
    endcase
  end

  // payload capture and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      value_r <= in_value;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      rear_r   <= '0;
      empty_r  <= 1'b1;
      del_ok_r <= 1'b0;
    end else if (cmd.exec) begin
      front_r  <= front_nxt;
      rear_r   <= rear_nxt;
      empty_r  <= empty_nxt;
      del_ok_r <= del_ok_nxt;
    end
  end

  // slot storage, at most one access per operation
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[addr] <= value_r;
    end
    if (cmd.exec && rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign out_status  = status_r;
  assign out_removed = del_ok_r ? $signed(rd_data_r) : 32'sd0;

endmodule

// ===== rtl/array_double_ended_queue_top.sv =====
// non-circular array deque holding up to DEPTH 32-bit items
// input channel: in_valid/in_ready with in_kind (0 insert rear, 1 insert
// front, 2 delete rear, 3 delete front) and in_value (ignored by deletes)
// result channel: out_valid/out_ready with out_status (0 ok, 1 rear full,
// 2 queue empty, 3 front insertion not possible) and out_removed (the
// deleted item on a successful delete, zero otherwise)
// exactly one result per item, in order
// the result is registered: the item passes through the S_EXEC state and
// its result is valid in S_DONE; the index update and the at most one
// slot-memory access happen in S_EXEC, and the next item is taken only
// once the result has been handed over
// a stalled receiver holds the result and in_ready stays low meanwhile
// reset empties the queue (front 0, rear 0, empty flag set); slot contents
// are not cleared and are only read after being written
module array_double_ended_queue_top #(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [1:0]  in_kind,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [1:0]  out_status,
  output logic signed [31:0] out_removed
);

  adq_pkg::cmd_t cmd;

  adq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  adq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_kind     (in_kind),
    .in_value    (in_value),
    .out_status  (out_status),
    .out_removed (out_removed)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int DEPTH       = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_OPS  = 1600;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] removed;
  } reply_t;

  // mirror of the deque contents, plus the replies still owed by the block
  class deque_mirror;
    int          front_pos;
    int          rear_pos;
    logic [31:0] cells [DEPTH];
    reply_t      owed [$];
    int          fail_count;

    function new();
      front_pos  = 0;
      rear_pos   = -1;
      fail_count = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function int occupancy();
      return rear_pos - front_pos + 1;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    endfunction

    // apply one accepted item and queue the reply it must produce
    function void note_op(logic [1:0] kind, logic [31:0] value);
      reply_t r;
      r.status  = adq_pkg::ST_OK;
      r.removed = '0;
      case (kind)
        adq_pkg::KIND_INS_REAR: begin
          if (rear_pos >= DEPTH - 1) begin
            r.status = adq_pkg::ST_REAR_FULL;
          end else begin
            rear_pos++;
            cells[rear_pos] = value;
          end
        end
        adq_pkg::KIND_INS_FRONT: begin
          if (front_pos > 0) begin
            front_pos--;
            cells[front_pos] = value;
          end else if (rear_pos < 0) begin
            rear_pos = 0;
            cells[0] = value;
          end else begin
            r.status = adq_pkg::ST_FRONT_BLOCKED;
          end
        end
        adq_pkg::KIND_DEL_REAR: begin
          if (front_pos > rear_pos) begin
            r.status = adq_pkg::ST_EMPTY;
          end else begin
            r.removed = cells[rear_pos];
            rear_pos--;
          end
        end
        default: begin
          if (front_pos > rear_pos) begin
            r.status = adq_pkg::ST_EMPTY;
          end else begin
            r.removed = cells[front_pos];
            front_pos++;
          end
        end
      endcase
      // emptied by a delete: indices go back to the reset position
      if (front_pos > rear_pos) begin
        front_pos = 0;
        rear_pos  = -1;
      end
      owed.push_back(r);
    endfunction

    function void check_reply(logic [1:0] status, logic [31:0] removed);
      reply_t r;
      if (owed.size() == 0) begin
        flag("unexpected reply, status", '0, {30'd0, status});
        return;
      end
      r = owed.pop_front();
      if (status !== r.status) flag("status", {30'd0, r.status}, {30'd0, status});
      if (removed !== r.removed) flag("removed", r.removed, removed);
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic        [1:0]  in_kind;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic        [1:0]  out_status;
  logic signed [31:0] out_removed;

  deque_mirror mirror;
  int          cycles;
  bit          tx_quiet;
  bit          rx_quiet;

  array_double_ended_queue_top #(.DEPTH(DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_removed(out_removed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("array_double_ended_queue_top verification failed");
      $finish;
    end
  end

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [31:0] draw_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // operation mix per phase: filling, front-end churn, draining, flat
  function automatic logic [1:0] draw_kind(int mix);
    int p;
    p = $urandom_range(0, 99);
    case (mix)
      0:       return p < 55 ? adq_pkg::KIND_INS_REAR :
                      p < 70 ? adq_pkg::KIND_INS_FRONT :
                      p < 85 ? adq_pkg::KIND_DEL_REAR : adq_pkg::KIND_DEL_FRONT;
      1:       return p < 35 ? adq_pkg::KIND_DEL_FRONT :
                      p < 70 ? adq_pkg::KIND_INS_FRONT :
                      p < 90 ? adq_pkg::KIND_INS_REAR : adq_pkg::KIND_DEL_REAR;
      2:       return p < 35 ? adq_pkg::KIND_DEL_REAR :
                      p < 70 ? adq_pkg::KIND_DEL_FRONT :
                      p < 85 ? adq_pkg::KIND_INS_REAR : adq_pkg::KIND_INS_FRONT;
      default: return 2'($urandom_range(0, 3));
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_op(logic [1:0] kind, logic [31:0] value);
    int gap;
    gap = draw_wait(tx_quiet);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_kind  = kind;
    in_value = value;
    do @(posedge clk); while (!in_ready);
    mirror.note_op(kind, value);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid = 1'b0;
    while (mirror.pending() != 0) @(negedge clk);
  endtask

  // receiver: random stalls before each item, with calm stretches
  initial begin
    int stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_quiet = ~rx_quiet;
      stall = draw_wait(rx_quiet);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      mirror.check_reply(out_status, out_removed);
      @(negedge clk);
    end
  end

  initial begin
    int mix;
    int run;
    int sent;
    bit toggle;
    mirror    = new();
    cycles    = 0;
    tx_quiet  = 1'b0;
    rx_quiet  = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_kind   = adq_pkg::KIND_INS_REAR;
    in_value  = '0;
    out_ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // empty queue, front insert into empty, then front blocked
    send_op(adq_pkg::KIND_DEL_REAR, 32'h1234_5678);
    send_op(adq_pkg::KIND_DEL_FRONT, 32'hffff_ffff);
    send_op(adq_pkg::KIND_INS_FRONT, 32'h8000_0000);
    send_op(adq_pkg::KIND_INS_FRONT, 32'h7fff_ffff);
    send_op(adq_pkg::KIND_INS_REAR, 32'hffff_ffff);
    send_op(adq_pkg::KIND_INS_REAR, 32'h0000_0000);
    for (int i = 0; i < 5; i++) send_op(adq_pkg::KIND_INS_REAR, 32'h7fff_ffff - i);
    // rear at last slot, then still full with room below the front
    send_op(adq_pkg::KIND_INS_REAR, 32'haaaa_aaaa);
    send_op(adq_pkg::KIND_DEL_FRONT, 32'h0);
    send_op(adq_pkg::KIND_DEL_FRONT, 32'h0);
    send_op(adq_pkg::KIND_INS_REAR, 32'h5555_5555);
    send_op(adq_pkg::KIND_INS_FRONT, 32'h5555_5555);
    send_op(adq_pkg::KIND_DEL_REAR, 32'hdead_beef);
    toggle = 1'b0;
    while (mirror.occupancy() > 0) begin
      send_op(toggle ? adq_pkg::KIND_DEL_FRONT : adq_pkg::KIND_DEL_REAR, 32'hffff_ffff);
      toggle = ~toggle;
    end
    send_op(adq_pkg::KIND_DEL_FRONT, 32'h0);
    send_op(adq_pkg::KIND_INS_FRONT, 32'h0000_0001);
    hold_until_drained();
    @(negedge clk);

    sent = 0;
    while (sent < RANDOM_OPS) begin
      mix      = $urandom_range(0, 3);
      run      = $urandom_range(20, 90);
      tx_quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < run && sent < RANDOM_OPS; i++) begin
        send_op(draw_kind(mix), draw_word());
        sent++;
      end
      if ($urandom_range(0, 3) == 0) hold_until_drained();
    end
    in_valid = 1'b0;

    while (mirror.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mirror.fail_count == 0 && mirror.pending() == 0) begin
      $display("array_double_ended_queue_top verification clean");
    end else begin
      $display("array_double_ended_queue_top verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/adq_pkg.sv
rtl/adq_ctrl.sv
rtl/adq_dpath.sv
rtl/array_double_ended_queue_top.sv
tb/sv/tb_top.sv
